// ===== hdl/xdp_pkg.sv =====
// ---------------------------------------------------------------------------
// xdp_pkg: shared types and constants of the duration text parser
// Character codes, parser state layout, result layout and the scaling
// of second fractions to milliseconds.
// ---------------------------------------------------------------------------
package xdp_pkg;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // Decimal places kept for seconds, 0 to 3.
  localparam int FRACTION_DIGITS = 3;
  localparam logic [1:0] FRAC_LIMIT = 2'(FRACTION_DIGITS);

  localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

  localparam int F_YEARS   = 0;
  localparam int F_MONTHS  = 1;
  localparam int F_DAYS    = 2;
  localparam int F_HOURS   = 3;
  localparam int F_MINUTES = 4;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_AFTER_MINUS = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_PREFIX = 2'd1,
    ERR_DESIGNATOR = 2'd2,
    ERR_NO_DESIGNATOR = 2'd3
  } err_code_t;

  typedef struct packed {
    phase_t           phase;
    logic             negative;
    logic             time_part;
    logic [30:0]      int_acc;
    logic [9:0]       frac_acc;
    logic [1:0]       frac_digits;
    logic [1:0]       dot_count;
    logic             pending;
    err_code_t        err;
    logic [4:0][30:0] mag;
    logic [40:0]      sec_milli;
  } state_t;

  typedef struct packed {
    err_code_t        code;
    logic [4:0][31:0] unit;
    logic [41:0]      milli;
  } result_t;

  // Fraction digits gathered so far, scaled to thousandths.
  function automatic logic [40:0] frac_to_milli(input logic [9:0] frac,
                                                input logic [1:0] digits);
    logic [40:0] wide;
    wide = 41'(frac);
    case (digits)
      2'd1:    frac_to_milli = 41'(wide * 41'd100);
      2'd2:    frac_to_milli = 41'(wide * 41'd10);
      2'd3:    frac_to_milli = wide;
      default: frac_to_milli = '0;
    endcase
  endfunction

endpackage

// ===== hdl/xdp_step.sv =====
// ---------------------------------------------------------------------------
// xdp_step: one character step of the duration parser
// Computes the parser state after one character and, for the final
// character, the signed result fields and status code.
// ---------------------------------------------------------------------------
module xdp_step
  import xdp_pkg::*;
(
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  state_t     cur,
  output state_t     nxt,
  output result_t    res
);

  state_t      upd;
  logic [34:0] int_wide;
  logic [3:0]  digit;
  logic        store_en;
  logic        clear_en;
  logic [40:0] sec_value;
  err_code_t   code;

  assign digit     = 4'(char_code - CH_0);
  assign int_wide  = {1'b0, cur.int_acc, 3'b000} + {3'b000, cur.int_acc, 1'b0}
                   + 35'(digit);
  assign sec_value = 41'(41'(cur.int_acc) * 41'd1000)
                   + frac_to_milli(cur.frac_acc, cur.frac_digits);

  always_comb begin
    upd      = cur;
    store_en = 1'b0;
    clear_en = 1'b0;
    if (cur.err == ERR_NONE) begin
      case (cur.phase)
        PH_FIRST: begin
          if (char_code == CH_P) begin
            upd.phase = PH_BODY;
          end else if (char_code == CH_MINUS) begin
            upd.negative = 1'b1;
            upd.phase    = PH_AFTER_MINUS;
          end else begin
            upd.err = ERR_PREFIX;
          end
        end
        PH_AFTER_MINUS: begin
          if (char_code == CH_P) begin
            upd.phase = PH_BODY;
          end else begin
            upd.err = ERR_PREFIX;
          end
        end
        PH_BODY: begin
          case (char_code) inside
            [CH_0:CH_9]: begin
              upd.pending = 1'b1;
              if (cur.dot_count == 2'd0) begin
                upd.int_acc = (int_wide > 35'(INT_SAT)) ? INT_SAT : int_wide[30:0];
              end else if (cur.dot_count == 2'd1 && cur.frac_digits < FRAC_LIMIT) begin
                upd.frac_acc    = 10'({cur.frac_acc, 3'b000} + {2'b00, cur.frac_acc, 1'b0}
                                      + 13'(digit));
                upd.frac_digits = cur.frac_digits + 2'd1;
              end
            end
            CH_DOT: begin
              upd.pending = 1'b1;
              if (cur.dot_count < 2'd2) begin
                upd.dot_count = cur.dot_count + 2'd1;
              end
            end
            CH_Y: begin
              upd.mag[F_YEARS] = cur.int_acc;
              clear_en = 1'b1;
            end
            CH_M: begin
              if (cur.time_part) begin
                upd.mag[F_MINUTES] = cur.int_acc;
              end else begin
                upd.mag[F_MONTHS] = cur.int_acc;
              end
              clear_en = 1'b1;
            end
            CH_D: begin
              upd.mag[F_DAYS] = cur.int_acc;
              clear_en = 1'b1;
            end
            CH_H: begin
              upd.mag[F_HOURS] = cur.int_acc;
              clear_en = 1'b1;
            end
            CH_S: begin
              store_en = 1'b1;
              clear_en = 1'b1;
            end
            CH_T: begin
              upd.time_part = 1'b1;
              clear_en = 1'b1;
            end
            default: begin
              upd.err = ERR_DESIGNATOR;
            end
          endcase
        end
        default: begin
          upd.err = ERR_PREFIX;
        end
      endcase
    end
    if (store_en) begin
      upd.sec_milli = sec_value;
    end
    if (clear_en) begin
      upd.int_acc     = '0;
      upd.frac_acc    = '0;
      upd.frac_digits = '0;
      upd.dot_count   = '0;
      upd.pending     = 1'b0;
    end
  end

  always_comb begin
    code = upd.err;
    if (code == ERR_NONE && upd.phase != PH_BODY) begin
      code = ERR_PREFIX;
    end
    if (code == ERR_NONE && upd.pending) begin
      code = ERR_NO_DESIGNATOR;
    end
    res.code = code;
    for (int i = 0; i < 5; i++) begin
      if (code != ERR_NONE) begin
        res.unit[i] = '0;
      end else if (upd.negative) begin
        res.unit[i] = 32'd0 - {1'b0, upd.mag[i]};
      end else begin
        res.unit[i] = {1'b0, upd.mag[i]};
      end
    end
    if (code != ERR_NONE) begin
      res.milli = '0;
    end else if (upd.negative) begin
      res.milli = 42'd0 - {1'b0, upd.sec_milli};
    end else begin
      res.milli = {1'b0, upd.sec_milli};
    end
  end

  always_comb begin
    if (last_char) begin
      nxt = '0;
    end else begin
      nxt = upd;
    end
  end

endmodule

// ===== hdl/xsd_duration_parser_core.sv =====
// ---------------------------------------------------------------------------
// xsd_duration_parser_core: streaming xsd:duration text parser
// Takes one ASCII character per beat and emits the parsed duration fields
// with a status code in one result beat after the final character.
// ---------------------------------------------------------------------------
// The slave channel carries one character per beat in s_axis_tdata, with
// s_axis_tlast marking the final character of a text. Each character is
// registered, then combinational logic folds it into the parser state.
// On the final character one result beat is loaded into the output
// register and shown on the master channel; the parser state returns to
// its reset value so the next text can follow on the very next beat.
// Throughput is one character per cycle, bounded by the state update loop
// (multiply-by-ten accumulate and designator decode), except under the stall below.
// When the receiver stalls, characters that end no text keep flowing;
// a final character waits in the input register until the result
// register is free, and s_axis_tready drops behind it.
// A synchronous active-high reset empties both registers and clears
// all parser state, including the stored fields.
// ---------------------------------------------------------------------------
module xsd_duration_parser_core
  import xdp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] char_code
  input  logic         s_axis_tlast,  // last_char
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [207:0] m_axis_tdata   // years, months, days, hours, minutes,
                                      // seconds_milli, error_code, zero pad
);

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;
  state_t     state;
  state_t     state_next;
  result_t    res;
  result_t    out_res;
  logic       out_free;
  logic       advance;
  logic       s_beat;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || advance;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  xdp_step u_step (
    .char_code (in_char),
    .last_char (in_last),
    .cur       (state),
    .nxt       (state_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      state         <= '0;
    end else begin
      if (s_beat) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        state <= state_next;
      end
      if (advance && in_last) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_beat) begin
      in_char <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
    if (advance && in_last) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {4'b0000, out_res.code, out_res.milli,
                         out_res.unit[F_MINUTES], out_res.unit[F_HOURS],
                         out_res.unit[F_DAYS], out_res.unit[F_MONTHS],
                         out_res.unit[F_YEARS]};

endmodule

// ===== tb/tb_xsd_duration_parser_core.sv =====
// ---------------------------------------------------------------------------
// tb_xsd_duration_parser_core: self-checking bench for the duration parser
// Streams duration texts one character per beat, first a table of directed
// texts, then random well-formed and broken texts under four phases of
// source idling and receiver stalls. The bench's behavioral parser or the
// directed table predicts each result beat, checked field by field in order.
// ---------------------------------------------------------------------------
module tb_xsd_duration_parser_core;
  import xdp_pkg::*;

  localparam int N_DIR = 20;
  localparam int CHARS_PER_PHASE = 250;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    err_code_t        code;
    logic [41:0]      milli;
    logic [4:0][31:0] unit;
  } duration_t;

  typedef struct packed {
    bit                 typed;
    err_code_t          code;
    logic [2:0]         fld;
    logic signed [63:0] val;
  } dir_expect_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'd0;   // [7:0] char_code
  logic         s_axis_tlast = 1'b0;   // last_char
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [207:0] m_axis_tdata;          // years, months, days, hours, minutes,
                                       // seconds_milli, error_code, zero pad

  xsd_duration_parser_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Parser state mirrored by the bench.
  phase_t      pr_phase = PH_FIRST;
  bit          pr_neg = 1'b0;
  bit          pr_time = 1'b0;
  logic [30:0] pr_int = '0;
  logic [9:0]  pr_frac = '0;
  logic [1:0]  pr_frac_n = '0;
  logic [1:0]  pr_dots = '0;
  bit          pr_pending = 1'b0;
  err_code_t   pr_err = ERR_NONE;
  logic [31:0] pr_unit_mag [5] = '{default: '0};
  logic [41:0] pr_sec_milli = '0;

  duration_t   durations_due[$];
  logic [7:0]  text_q[$];
  int          mismatches = 0;
  int unsigned cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  string unit_name [5] = '{"years", "months", "days", "hours", "minutes"};

  string dir_txt [N_DIR] = '{
    "P", "-", "X", "-Q", "\377P", "-P", "P1Z", "P\377", "P12", "PT.",
    "P99999999999Y", "-P2147483647D", "PT2147483647.999S",
    "-PT99999999999.99999S", "P1Y2M3DT4H5M6.7S", "-P5T6H7M", "PT1.2.3S",
    "P1Y2YMT.5S", "P1Z2Y", "P0.05S"
  };

  dir_expect_t dir_exp [N_DIR] = '{
    '{1'b1, ERR_NONE,          3'd0, 64'sd0},
    '{1'b1, ERR_PREFIX,        3'd0, 64'sd0},
    '{1'b1, ERR_PREFIX,        3'd0, 64'sd0},
    '{1'b1, ERR_PREFIX,        3'd0, 64'sd0},
    '{1'b1, ERR_PREFIX,        3'd0, 64'sd0},
    '{1'b1, ERR_NONE,          3'd0, 64'sd0},
    '{1'b1, ERR_DESIGNATOR,    3'd0, 64'sd0},
    '{1'b1, ERR_DESIGNATOR,    3'd0, 64'sd0},
    '{1'b1, ERR_NO_DESIGNATOR, 3'd0, 64'sd0},
    '{1'b1, ERR_NO_DESIGNATOR, 3'd0, 64'sd0},
    '{1'b1, ERR_NONE,          3'd0, 64'sd2147483647},
    '{1'b1, ERR_NONE,          3'd2, -64'sd2147483647},
    '{1'b1, ERR_NONE,          3'd5, 64'sd2147483647999},
    '{1'b1, ERR_NONE,          3'd5, -64'sd2147483647999},
    '{1'b0, ERR_NONE,          3'd0, 64'sd0},
    '{1'b0, ERR_NONE,          3'd0, 64'sd0},
    '{1'b0, ERR_NONE,          3'd0, 64'sd0},
    '{1'b0, ERR_NONE,          3'd0, 64'sd0},
    '{1'b1, ERR_DESIGNATOR,    3'd0, 64'sd0},
    '{1'b0, ERR_NONE,          3'd0, 64'sd0}
  };

  task automatic clear_number();
    pr_int = '0;
    pr_frac = '0;
    pr_frac_n = '0;
    pr_dots = '0;
    pr_pending = 1'b0;
  endtask

  task automatic clear_parser();
    pr_phase = PH_FIRST;
    pr_neg = 1'b0;
    pr_time = 1'b0;
    pr_err = ERR_NONE;
    clear_number();
    for (int i = 0; i < 5; i++) pr_unit_mag[i] = '0;
    pr_sec_milli = '0;
  endtask

  task automatic store_unit(input int slot);
    pr_unit_mag[slot] = {1'b0, pr_int};
    clear_number();
  endtask

  task automatic store_seconds();
    logic [41:0] scale;
    case (pr_frac_n)
      2'd0:    scale = 42'd1000;
      2'd1:    scale = 42'd100;
      2'd2:    scale = 42'd10;
      default: scale = 42'd1;
    endcase
    pr_sec_milli = 42'(pr_int) * 42'd1000 + 42'(pr_frac) * scale;
    clear_number();
  endtask

  task automatic body_char(input logic [7:0] c);
    logic [63:0] wide;
    if (c >= CH_0 && c <= CH_9) begin
      pr_pending = 1'b1;
      if (pr_dots == 2'd0) begin
        wide = 64'(pr_int) * 64'd10 + 64'(c - CH_0);
        pr_int = (wide > 64'(INT_SAT)) ? INT_SAT : wide[30:0];
      end else if (pr_dots == 2'd1 && pr_frac_n < FRACTION_DIGITS) begin
        pr_frac = pr_frac * 10'd10 + 10'(c - CH_0);
        pr_frac_n = pr_frac_n + 2'd1;
      end
    end else begin
      case (c)
        CH_DOT: begin
          pr_pending = 1'b1;
          if (pr_dots < 2'd2) pr_dots = pr_dots + 2'd1;
        end
        CH_Y: store_unit(F_YEARS);
        CH_M: store_unit(pr_time ? F_MINUTES : F_MONTHS);
        CH_D: store_unit(F_DAYS);
        CH_H: store_unit(F_HOURS);
        CH_S: store_seconds();
        CH_T: begin
          pr_time = 1'b1;
          clear_number();
        end
        default: pr_err = ERR_DESIGNATOR;
      endcase
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input bit last);
    duration_t res;
    err_code_t code;
    if (pr_err == ERR_NONE) begin
      case (pr_phase)
        PH_FIRST: begin
          if (c == CH_P) begin
            pr_phase = PH_BODY;
          end else if (c == CH_MINUS) begin
            pr_neg = 1'b1;
            pr_phase = PH_AFTER_MINUS;
          end else begin
            pr_err = ERR_PREFIX;
          end
        end
        PH_AFTER_MINUS: begin
          if (c == CH_P) pr_phase = PH_BODY;
          else pr_err = ERR_PREFIX;
        end
        default: body_char(c);
      endcase
    end
    if (last) begin
      code = pr_err;
      if (code == ERR_NONE && pr_phase != PH_BODY) code = ERR_PREFIX;
      if (code == ERR_NONE && pr_pending) code = ERR_NO_DESIGNATOR;
      res = '0;
      res.code = code;
      if (code == ERR_NONE) begin
        for (int i = 0; i < 5; i++)
          res.unit[i] = pr_neg ? -pr_unit_mag[i] : pr_unit_mag[i];
        res.milli = pr_neg ? -pr_sec_milli : pr_sec_milli;
      end
      durations_due.push_back(res);
      clear_parser();
    end
  endtask

  task automatic send_char(input logic [7:0] c, input bit last);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    parse_char(c, last);
  endtask

  task automatic send_text();
    for (int k = 0; k < text_q.size(); k++)
      send_char(text_q[k], k == text_q.size() - 1);
  endtask

  task automatic put_number(input bit seconds);
    int r;
    r = $urandom_range(0, 99);
    if (r >= 10) begin
      repeat (r < 88 ? $urandom_range(1, 3) : $urandom_range(8, 12))
        text_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 99) < (seconds ? 40 : 5)) begin
      text_q.push_back(CH_DOT);
      repeat ($urandom_range(0, 5)) text_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 19) == 0) begin
        text_q.push_back(CH_DOT);
        repeat ($urandom_range(0, 3)) text_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
      end
    end
  endtask

  task automatic build_text();
    int kind;
    logic [7:0] des;
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      if (kind < 6) text_q.push_back(CH_P);
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) text_q.push_back(CH_MINUS);
      text_q.push_back(CH_P);
      if (kind < 70) begin
        if ($urandom_range(0, 1)) begin put_number(1'b0); text_q.push_back(CH_Y); end
        if ($urandom_range(0, 1)) begin put_number(1'b0); text_q.push_back(CH_M); end
        if ($urandom_range(0, 1)) begin put_number(1'b0); text_q.push_back(CH_D); end
        if ($urandom_range(0, 9) < 6) begin
          text_q.push_back(CH_T);
          if ($urandom_range(0, 1)) begin put_number(1'b0); text_q.push_back(CH_H); end
          if ($urandom_range(0, 1)) begin put_number(1'b0); text_q.push_back(CH_M); end
          if ($urandom_range(0, 1)) begin put_number(1'b1); text_q.push_back(CH_S); end
        end
      end else begin
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 5))
            0:       des = CH_Y;
            1:       des = CH_M;
            2:       des = CH_D;
            3:       des = CH_H;
            4:       des = CH_S;
            default: des = CH_T;
          endcase
          put_number(des == CH_S);
          text_q.push_back(des);
        end
      end
      if (kind >= 85) begin
        case ($urandom_range(0, 3))
          0: text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(0, 255)));
          1: repeat ($urandom_range(1, 4)) text_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
          2: if (text_q.size() > 1) void'(text_q.pop_back());
          default: text_q.push_back(CH_DOT);
        endcase
      end
    end
  endtask

  task automatic report_fault(input string what, input logic [63:0] want,
                              input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : result_check
    duration_t seen;
    duration_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      for (int i = 0; i < 5; i++) seen.unit[i] = m_axis_tdata[32*i +: 32];
      seen.milli = m_axis_tdata[201:160];
      seen.code = err_code_t'(m_axis_tdata[203:202]);
      if (durations_due.size() == 0) begin
        report_fault("unexpected result beat", 64'd0, 64'(seen.code));
      end else begin
        want = durations_due.pop_front();
        for (int i = 0; i < 5; i++)
          if (seen.unit[i] !== want.unit[i])
            report_fault(unit_name[i], 64'(want.unit[i]), 64'(seen.unit[i]));
        if (seen.milli !== want.milli)
          report_fault("seconds_milli", 64'(want.milli), 64'(seen.milli));
        if (seen.code !== want.code)
          report_fault("error_code", 64'(want.code), 64'(seen.code));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int idle_tab [4];
    int stall_tab [4];
    int sent;
    string s;
    duration_t typed;
    idle_tab = '{0, 53, 0, 36};
    stall_tab = '{0, 0, 53, 36};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      s = dir_txt[r];
      for (int k = 0; k < s.len(); k++) send_char(s[k], k == s.len() - 1);
      if (dir_exp[r].typed) begin
        typed = '0;
        typed.code = dir_exp[r].code;
        if (dir_exp[r].code == ERR_NONE) begin
          if (dir_exp[r].fld < 3'd5) typed.unit[dir_exp[r].fld] = dir_exp[r].val[31:0];
          else typed.milli = dir_exp[r].val[41:0];
        end
        durations_due[durations_due.size() - 1] = typed;
      end
    end

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_tab[p];
      stall_pct = stall_tab[p];
      sent = 0;
      while (sent < CHARS_PER_PHASE) begin
        build_text();
        send_text();
        sent += text_q.size();
      end
      s_axis_tvalid <= 1'b0;
      while (durations_due.size() != 0) @(posedge clk);
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
